### hw/rtl/mcpt_pkg.sv
// shared types and codes of the multi-channel pulse timer
package mcpt_pkg;

    localparam int PIN_W  = 6;
    localparam int DUR_W  = 16;
    localparam int TIME_W = 32;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // result kinds
    localparam logic RKIND_STATUS = 1'b0;
    localparam logic RKIND_DRIVE  = 1'b1;

    // request status codes
    localparam logic [1:0] ST_STARTED = 2'd0;
    localparam logic [1:0] ST_RETRIG  = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [PIN_W-1:0] PIN_FREE = '0;

    typedef struct packed {
        logic              kind;
        logic [PIN_W-1:0]  pin;
        logic [DUR_W-1:0]  duration;
        logic              retrigger;
        logic              polarity;
    } t_in;

    typedef struct packed {
        logic              result_kind;
        logic [1:0]        status;
        logic [PIN_W-1:0]  drive_pin;
        logic              drive_level;
        logic              last;
    } t_out;

    // one entry of the slot table
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [DUR_W-1:0]  length;
        logic [TIME_W-1:0] start;
        logic              active_high;
    } t_slot;

endpackage

### hw/rtl/mcpt_slot_ram.sv
// slot table memory: one write port, one registered read port
module mcpt_slot_ram #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  mcpt_pkg::t_slot    i_wdata,
    input  logic [IDX_W-1:0]   i_raddr,
    output mcpt_pkg::t_slot    o_rdata
);
    import mcpt_pkg::*;

    t_slot mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mcpt_out_stage.sv
// output register between the controller and the result channel
module mcpt_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mcpt_pkg::t_out i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mcpt_pkg::t_out o_data
);
    import mcpt_pkg::*;

    logic r_valid;
    t_out r_data;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/multi_channel_pulse_timer.sv
// multi-channel retriggerable pulse timer: top level with scan controller
// a request is taken only while idle, so a new item waits until the last one is fully handled
// the scan reads one slot per cycle unless result back-pressure holds it, a start on pin zero
//   skips the scan, and a start that takes a slot sends its drive event after the status beat
// result back-pressure stalls the tick scan while an expired slot waits to be sent
// reset: synchronous active low, all slots free and the millisecond counter at zero
module multi_channel_pulse_timer #(
    parameter int SLOT_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mcpt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mcpt_pkg::t_out o_out_data
);
    import mcpt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_STATUS = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // per-slot occupancy, the memory only holds payload
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [TIME_W-1:0]     r_time;
    t_in                   r_req;
    logic [IDX_W-1:0]      r_idx, n_idx;

    // first slot already owned by the requested pin
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    t_slot                 r_hit_slot, n_hit_slot;

    // drive event held back until we know whether it is the last one
    logic                  r_hold_v, n_hold_v;
    logic [PIN_W-1:0]      r_hold_pin, n_hold_pin;
    logic                  r_hold_lvl, n_hold_lvl;

    // slot ram ports
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    t_slot                 w_wdata;
    logic [IDX_W-1:0]      w_raddr;
    t_slot                 w_rd;

    // result path
    logic                  w_emit;
    t_out                  w_emit_data;
    logic                  w_can_emit;

    logic                  w_in_acc;
    logic                  w_tick;
    logic                  w_expire;
    logic                  w_match;
    logic                  w_advance;
    logic [IDX_W-1:0]      w_free_idx;
    logic                  w_full;
    logic [1:0]            w_status;
    logic [TIME_W-1:0]     w_elapsed;

    mcpt_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    mcpt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_emit),
        .o_ready (w_can_emit),
        .i_data  (w_emit_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_tick     = (r_req.kind == KIND_TICK);

    // slot being scanned: data of r_idx sits on the ram output
    assign w_elapsed = r_time - w_rd.start;
    assign w_expire  = r_valid[r_idx] && (w_elapsed > TIME_W'(w_rd.length));
    assign w_match   = r_valid[r_idx] && (w_rd.pin == r_req.pin);

    // a tick stalls only when an expiry must push out the held event and the output stage is not ready
    assign w_advance = !(w_tick && w_expire && r_hold_v && !w_can_emit);

    // lowest free slot
    always_comb begin
        w_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_full = &r_valid;

    always_comb begin
        if (r_req.pin == PIN_FREE) begin
            w_status = ST_REFUSED;
        end else if (r_hit) begin
            w_status = r_req.retrigger ? ST_RETRIG : ST_REFUSED;
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_STARTED;
        end
    end

    // read address: slot zero while idle, next slot when the scan moves on, else hold
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = '0;
            S_SCAN:  w_raddr = (w_advance && r_idx != LAST_IDX) ? r_idx + IDX_W'(1) : r_idx;
            default: w_raddr = r_idx;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_slot = r_hit_slot;
        n_hold_v   = r_hold_v;
        n_hold_pin = r_hold_pin;
        n_hold_lvl = r_hold_lvl;
        w_we       = 1'b0;
        w_waddr    = w_free_idx;
        w_wdata    = '{pin: r_req.pin, length: r_req.duration, start: r_time,
                       active_high: r_req.polarity};
        w_emit      = 1'b0;
        w_emit_data = '{result_kind: RKIND_DRIVE, status: ST_STARTED,
                        drive_pin: r_hold_pin, drive_level: r_hold_lvl, last: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_idx = '0;
                    n_hit = 1'b0;
                    // pin zero request needs no scan
                    if (i_in_data.kind == KIND_START && i_in_data.pin == PIN_FREE) begin
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_tick) begin
                    if (w_expire && w_advance) begin
                        // the earlier expiry is not the last one
                        w_emit     = r_hold_v;
                        n_hold_v   = 1'b1;
                        n_hold_pin = w_rd.pin;
                        n_hold_lvl = !w_rd.active_high;
                        n_valid[r_idx] = 1'b0;
                    end
                end else if (w_match && !r_hit) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_slot = w_rd;
                end
                if (w_advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = w_tick ? S_FLUSH : S_STATUS;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_STATUS: begin
                w_emit_data = '{result_kind: RKIND_STATUS, status: w_status,
                                drive_pin: PIN_FREE, drive_level: 1'b0,
                                last: (w_status != ST_STARTED)};
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    case (w_status)
                        ST_RETRIG: begin
                            // restart timing only, length and polarity kept
                            w_we    = 1'b1;
                            w_waddr = r_hit_idx;
                            w_wdata = r_hit_slot;
                            w_wdata.start = r_time;
                            n_state = S_IDLE;
                        end
                        ST_STARTED: begin
                            w_we       = 1'b1;
                            n_valid[w_free_idx] = 1'b1;
                            n_hold_v   = 1'b1;
                            n_hold_pin = r_req.pin;
                            n_hold_lvl = r_req.polarity;
                            n_state    = S_FLUSH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                w_emit_data.last = 1'b1;
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (w_can_emit) begin
                    w_emit   = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_time   <= '0;
            r_hold_v <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_hold_v <= n_hold_v;
            r_hit    <= n_hit;
            if (w_in_acc && i_in_data.kind == KIND_TICK) begin
                r_time <= r_time + TIME_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_data;
        end
        r_idx      <= n_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_slot <= n_hit_slot;
        r_hold_pin <= n_hold_pin;
        r_hold_lvl <= n_hold_lvl;
    end

`ifndef SYNTHESIS
    // every accepted tick moves the counter by one
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.kind == KIND_TICK) |=> r_time == $past(r_time) + TIME_W'(1))
        else $error("millisecond counter did not advance on tick");

    // a written slot is occupied afterwards
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_valid[$past(w_waddr)])
        else $error("slot written but not marked occupied");

    // no drive event is left behind once the block is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held drive event lost");

    // an expired slot is freed
    a_expire_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_tick && w_expire && w_advance) |=> !r_valid[$past(r_idx)])
        else $error("expired slot still occupied");
`endif

endmodule

### bench/multi_channel_pulse_timer_tb.sv
// testbench of the multi-channel pulse timer: self-predicting, random stimulus and back-pressure
module multi_channel_pulse_timer_tb;
    import mcpt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int TAIL_ITEMS   = 60;      // last items are sent with no idling on either side
    localparam int HOLD_AT      = 40;      // items sent before the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8 * (SLOTS + 3);
    localparam int RANDOM_ITEMS = 410;
    localparam int PRINT_CAP    = 40;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    multi_channel_pulse_timer #(.SLOT_COUNT(SLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // predicted slot table and millisecond counter
    logic [PIN_W-1:0]  tab_pin   [SLOTS];
    logic [DUR_W-1:0]  tab_len   [SLOTS];
    logic [TIME_W-1:0] tab_start [SLOTS];
    logic              tab_hi    [SLOTS];
    int                tab_busy;
    logic [TIME_W-1:0] ms_now;

    t_in  stimulus_q [$];   // items waiting to be offered
    t_out awaited    [$];   // result beats predicted but not yet seen

    int errors       = 0;
    int n_results    = 0;
    int n_starts     = 0;
    int n_ticks      = 0;
    int n_drives     = 0;
    int n_retrig     = 0;
    int n_refused    = 0;
    int n_full       = 0;
    int widest_tick  = 0;
    int sent_count   = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    logic hold_done  = 1'b0;
    logic took_in    = 1'b0;
    logic calm       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    task automatic log_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch on result %0d: %s got %0d want %0d", n_results, what, got, want);
    endtask

    function automatic t_out status_beat(input logic [1:0] code, input logic last);
        t_out b;
        b             = '0;
        b.result_kind = RKIND_STATUS;
        b.status      = code;
        b.last        = last;
        return b;
    endfunction

    function automatic t_out drive_beat(input logic [PIN_W-1:0] pin, input logic level);
        t_out b;
        b             = '0;
        b.result_kind = RKIND_DRIVE;
        b.status      = ST_STARTED;
        b.drive_pin   = pin;
        b.drive_level = level;
        return b;
    endfunction

    // works out the beats one accepted item causes and queues them
    task automatic compute_pulse_results(input t_in it);
        t_out              ev;
        t_out              expired [$];
        logic [TIME_W-1:0] elapsed;
        int                s;
        int                hit;
        hit = -1;
        if (it.kind == KIND_TICK) begin
            n_ticks++;
            ms_now = ms_now + 1;
            for (s = 0; s < SLOTS; s++) begin
                elapsed = ms_now - tab_start[s];
                if (tab_pin[s] != PIN_FREE && elapsed > {{(TIME_W-DUR_W){1'b0}}, tab_len[s]}) begin
                    // idle level is the opposite of the active one
                    expired.push_back(drive_beat(tab_pin[s], ~tab_hi[s]));
                    tab_pin[s] = PIN_FREE;
                    if (tab_busy > 0)
                        tab_busy--;
                end
            end
            if (expired.size() > 0)
                expired[expired.size()-1].last = 1'b1;
            if (expired.size() > widest_tick)
                widest_tick = expired.size();
            n_drives += expired.size();
            foreach (expired[k])
                awaited.push_back(expired[k]);
        end else begin
            n_starts++;
            for (s = 0; s < SLOTS; s++)
                if (hit < 0 && tab_pin[s] == it.pin)
                    hit = s;
            if (it.pin == PIN_FREE) begin
                // the free marker can never be claimed
                n_refused++;
                awaited.push_back(status_beat(ST_REFUSED, 1'b1));
            end else if (hit >= 0) begin
                if (it.retrigger) begin
                    // only the start time moves, length and polarity stay
                    tab_start[hit] = ms_now;
                    n_retrig++;
                    awaited.push_back(status_beat(ST_RETRIG, 1'b1));
                end else begin
                    n_refused++;
                    awaited.push_back(status_beat(ST_REFUSED, 1'b1));
                end
            end else if (tab_busy >= SLOTS) begin
                n_full++;
                awaited.push_back(status_beat(ST_FULL, 1'b1));
            end else begin
                for (s = 0; s < SLOTS; s++)
                    if (hit < 0 && tab_pin[s] == PIN_FREE)
                        hit = s;
                tab_pin[hit]   = it.pin;
                tab_len[hit]   = it.duration;
                tab_start[hit] = ms_now;
                tab_hi[hit]    = it.polarity;
                tab_busy++;
                n_drives++;
                awaited.push_back(status_beat(ST_STARTED, 1'b0));
                ev      = drive_beat(it.pin, it.polarity);
                ev.last = 1'b1;
                awaited.push_back(ev);
            end
        end
    endtask

    task automatic add_start(input int pin, input int dur, input bit retrig, input bit pol);
        t_in it;
        it           = '0;
        it.kind      = KIND_START;
        it.pin       = pin[PIN_W-1:0];
        it.duration  = dur[DUR_W-1:0];
        it.retrigger = retrig;
        it.polarity  = pol;
        stimulus_q.push_back(it);
    endtask

    // a tick ignores every other field, so those carry noise
    task automatic add_tick();
        t_in it;
        it           = '0;
        it.kind      = KIND_TICK;
        it.pin       = PIN_W'($urandom_range(0, 63));
        it.duration  = DUR_W'($urandom_range(0, 65535));
        it.retrigger = $urandom_range(0, 1);
        it.polarity  = $urandom_range(0, 1);
        stimulus_q.push_back(it);
    endtask

    // input beats and predictor on the accept edge, result beats checked in order
    always @(posedge i_clk) begin
        t_out want;
        took_in <= in_valid && in_ready;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                n_results++;
                if (awaited.size() == 0) begin
                    log_mismatch("result beat with nothing outstanding, raw", out_data, 0);
                end else begin
                    want = awaited.pop_front();
                    if (out_data.result_kind !== want.result_kind)
                        log_mismatch("result_kind", out_data.result_kind, want.result_kind);
                    if (out_data.status !== want.status)
                        log_mismatch("status", out_data.status, want.status);
                    if (out_data.drive_pin !== want.drive_pin)
                        log_mismatch("drive_pin", out_data.drive_pin, want.drive_pin);
                    if (out_data.drive_level !== want.drive_level)
                        log_mismatch("drive_level", out_data.drive_level, want.drive_level);
                    if (out_data.last !== want.last)
                        log_mismatch("last", out_data.last, want.last);
                end
            end
            if (in_valid && in_ready)
                compute_pulse_results(in_data);
        end
    end

    // sender: offers queued items, with short random gaps outside the tail
    always @(negedge i_clk) begin
        calm <= (stimulus_q.size() < TAIL_ITEMS);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || took_in) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (stimulus_q.size() > 0) begin
                in_data    <= stimulus_q.pop_front();
                in_valid   <= 1'b1;
                sent_count <= sent_count + 1;
                if (stimulus_q.size() >= TAIL_ITEMS && $urandom_range(0, 4) == 0)
                    gap_left <= $urandom_range(1, 4);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // one long hold-off of the receiver so the block backs up into its input
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: random stall bursts, none in the tail
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        int  n_rand;
        int  burst;
        int  r;
        int  k;
        int  pin;
        int  dur;
        n_rand   = 0;
        tab_busy = 0;
        ms_now   = '0;
        for (k = 0; k < SLOTS; k++) begin
            tab_pin[k]   = PIN_FREE;
            tab_len[k]   = '0;
            tab_start[k] = '0;
            tab_hi[k]    = 1'b0;
        end

        // directed part
        add_start(0, 16'hFFFF, 1, 1);          // free marker pin is refused
        add_start(1, 0, 0, 1);                 // zero duration
        add_start(1, 5, 0, 0);                 // duplicate without retrigger
        add_start(1, 7, 1, 0);                 // retrigger keeps length and polarity
        add_tick();                            // zero duration slot expires here
        for (k = 2; k <= 9; k++)
            add_start(k, 2, 0, k[0]);          // fill every slot
        add_start(10, 16'hFFFF, 0, 1);         // table full
        add_start(5, 16'hFFFF, 1, 1);          // retrigger on a full table
        add_tick();
        add_tick();
        add_tick();                            // all slots expire on one tick
        add_start(63, 16'hFFFF, 0, 0);         // longest pulse on the top pin
        add_start(63, 16'h0000, 1, 1);
        add_start(63, 16'h5555, 0, 1);
        stimulus_q.push_back('{kind: KIND_TICK, pin: '1, duration: '1,
                               retrigger: 1'b1, polarity: 1'b1});

        // random part: bursts of requests, then bursts of ticks
        while (n_rand < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 6);
            for (k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    pin = 0;
                    dur = $urandom_range(0, 65535);
                end else if (r < 13) begin
                    // pin 63 holds a pulse that outlives the run, so any length is safe
                    pin = 63;
                    dur = $urandom_range(0, 65535);
                end else begin
                    pin = (r < 85) ? $urandom_range(1, 12) : $urandom_range(1, 62);
                    dur = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 150)
                                                       : $urandom_range(0, 24);
                end
                add_start(pin, dur, $urandom_range(0, 1), $urandom_range(0, 1));
            end
            n_rand += burst;
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst; k++)
                add_tick();
            n_rand += burst;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stimulus_q.size() != 0 || in_valid)
            @(posedge i_clk);
        while (awaited.size() != 0)
            @(posedge i_clk);
        // a tick with no expiry gives no beat, so give the last scan time to finish
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited.size() != 0)
            log_mismatch("result beats never delivered", 0, awaited.size());

        $display("covered %0d start requests and %0d ticks, %0d result beats checked",
                 n_starts, n_ticks, n_results);
        $display("%0d pin drives, %0d retriggers, %0d refusals, %0d table-full, widest tick %0d",
                 n_drives, n_retrig, n_refused, n_full, widest_tick);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
